### rtl/lse_pkg.sv
// Shared types and constants of the LSB stego stream extractor.
`default_nettype none

package lse_pkg;

    localparam int KEY_MAX_CHARS = 9;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_INDEX_W   = 2;
    localparam int SEC_W         = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_SKIP  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_FIRST    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_NINTH    = 2'd3;

    localparam logic [SEC_W-1:0] SEC_MAGIC = 2'd0;
    localparam logic [SEC_W-1:0] SEC_EXT   = 2'd1;
    localparam logic [SEC_W-1:0] SEC_DATA  = 2'd2;

    localparam logic [7:0] HEADER_SKIP_RESET = 8'd54;

    typedef struct packed {
        logic [7:0]  header_skip;
        logic [3:0]  passkey_length;
        logic [63:0] passkey_first_chars;
        logic [7:0]  passkey_ninth_char;
    } lse_cfg_t;

    typedef struct packed {
        logic [SEC_W-1:0] section;
        logic             char_valid;
        logic [7:0]       char_value;
        logic             section_end;
        logic             key_match;
        logic             finished;
    } lse_result_t;

endpackage

`default_nettype wire

### rtl/lse_key.sv
// Passkey character select and compare for the magic section.
`default_nettype none

module lse_key #(
    parameter int LENGTH_BITS = 32
) (
    input  wire lse_pkg::lse_cfg_t  cfg,
    input  wire [LENGTH_BITS-1:0]   char_index,
    input  wire [7:0]               char_value,
    output logic                    char_ok,
    output logic                    length_ok
);

    logic [7:0] key_char;

    always_comb
    begin
        key_char = cfg.passkey_ninth_char;
        for (int i = 0; i < 8; i++)
        begin
            if (char_index[3:0] == 4'(i))
            begin
                key_char = cfg.passkey_first_chars[63-8*i -: 8];
            end
        end
    end

    assign char_ok = (char_index < LENGTH_BITS'(lse_pkg::KEY_MAX_CHARS)) &&
                     (key_char == char_value);
    assign length_ok = (cfg.passkey_length <= 4'(lse_pkg::KEY_MAX_CHARS));

endmodule

`default_nettype wire

### rtl/lse_parse.sv
// Parser state machine: header skip, length and character sections.
`default_nettype none

module lse_parse #(
    parameter int LENGTH_BITS = 32
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      step,
    input  wire                      data_bit,
    input  wire lse_pkg::lse_cfg_t   cfg,
    output logic                     res_valid,
    output lse_pkg::lse_result_t     res
);

    localparam int CW = $clog2(LENGTH_BITS);

    localparam logic [3:0] PH_HEADER = 4'd0;
    localparam logic [3:0] PH_LEN0   = 4'd1;
    localparam logic [3:0] PH_LEN1   = 4'd2;
    localparam logic [3:0] PH_LEN2   = 4'd3;
    localparam logic [3:0] PH_CHR0   = 4'd4;
    localparam logic [3:0] PH_CHR1   = 4'd5;
    localparam logic [3:0] PH_CHR2   = 4'd6;
    localparam logic [3:0] PH_STOP   = 4'd7;
    localparam logic [3:0] PH_DONE   = 4'd8;

    logic [3:0]             phase_reg, phase_next, phase_eff;
    logic [7:0]             header_count_reg, header_count_next;
    logic [CW-1:0]          bit_count_reg, bit_count_next;
    logic [LENGTH_BITS-1:0] bit_shift_reg, bit_shift_next;
    logic [LENGTH_BITS-1:0] section_length_reg, section_length_next;
    logic [LENGTH_BITS-1:0] char_index_reg, char_index_next;
    logic                   key_equal_reg, key_equal_next;

    logic [LENGTH_BITS-1:0] len_word;
    logic [7:0]             chr_word;
    logic [lse_pkg::SEC_W-1:0] sec;
    logic                   char_ok, length_ok, key_eq_new, match, close;

    assign len_word = {bit_shift_reg[LENGTH_BITS-2:0], data_bit};
    assign chr_word = {bit_shift_reg[6:0], data_bit};

    lse_key #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_key (
        .cfg        (cfg),
        .char_index (char_index_reg),
        .char_value (chr_word),
        .char_ok    (char_ok),
        .length_ok  (length_ok)
    );

    // Once the header count is reached the same byte already carries a length bit.
    assign phase_eff = (phase_reg == PH_HEADER && header_count_reg >= cfg.header_skip) ?
                       PH_LEN0 : phase_reg;

    always_comb
    begin
        phase_next          = phase_reg;
        header_count_next   = header_count_reg;
        bit_count_next      = bit_count_reg;
        bit_shift_next      = bit_shift_reg;
        section_length_next = section_length_reg;
        char_index_next     = char_index_reg;
        key_equal_next      = key_equal_reg;
        res_valid           = 1'b0;
        res                 = '0;
        sec                 = lse_pkg::SEC_MAGIC;
        key_eq_new          = key_equal_reg;
        close               = 1'b0;

        unique case (phase_eff) inside
            PH_HEADER:
            begin
                header_count_next = header_count_reg + 8'd1;
            end
            PH_LEN0, PH_LEN1, PH_LEN2:
            begin
                sec        = lse_pkg::SEC_W'(phase_eff - PH_LEN0);
                phase_next = phase_eff;
                if (bit_count_reg != CW'(LENGTH_BITS - 1))
                begin
                    bit_count_next = bit_count_reg + CW'(1);
                    bit_shift_next = len_word;
                end
                else
                begin
                    section_length_next = len_word;
                    bit_count_next      = '0;
                    bit_shift_next      = '0;
                    char_index_next     = '0;
                    if (sec == lse_pkg::SEC_MAGIC)
                    begin
                        key_eq_new = length_ok &&
                            (len_word == {{(LENGTH_BITS-4){1'b0}}, cfg.passkey_length});
                    end
                    key_equal_next = key_eq_new;
                    if (len_word == '0)
                    begin
                        // empty section: one marker result with no character
                        close           = 1'b1;
                        res_valid       = 1'b1;
                        res.section     = sec;
                        res.section_end = 1'b1;
                    end
                    else
                    begin
                        phase_next = phase_eff + (PH_CHR0 - PH_LEN0);
                    end
                end
            end
            PH_CHR0, PH_CHR1, PH_CHR2:
            begin
                sec = lse_pkg::SEC_W'(phase_eff - PH_CHR0);
                if (bit_count_reg != CW'(7))
                begin
                    bit_count_next = bit_count_reg + CW'(1);
                    bit_shift_next = {{(LENGTH_BITS-8){1'b0}}, chr_word};
                end
                else
                begin
                    bit_count_next  = '0;
                    bit_shift_next  = '0;
                    if (sec == lse_pkg::SEC_MAGIC)
                    begin
                        key_eq_new = key_equal_reg && char_ok;
                    end
                    key_equal_next  = key_eq_new;
                    char_index_next = char_index_reg + LENGTH_BITS'(1);
                    res_valid       = 1'b1;
                    res.section     = sec;
                    res.char_valid  = 1'b1;
                    res.char_value  = chr_word;
                    if (char_index_reg + LENGTH_BITS'(1) == section_length_reg)
                    begin
                        close           = 1'b1;
                        res.section_end = 1'b1;
                    end
                end
            end
            default:
            begin
                // stopped or done: bytes are dropped until reset
            end
        endcase

        match = close && (sec == lse_pkg::SEC_MAGIC) && key_eq_new;
        if (close)
        begin
            bit_count_next  = '0;
            bit_shift_next  = '0;
            char_index_next = '0;
            res.key_match   = match;
            res.finished    = (sec == lse_pkg::SEC_DATA);
            if (sec == lse_pkg::SEC_MAGIC)
            begin
                phase_next = match ? PH_LEN1 : PH_STOP;
            end
            else if (sec == lse_pkg::SEC_EXT)
            begin
                phase_next = PH_LEN2;
            end
            else
            begin
                phase_next = PH_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_HEADER;
            header_count_reg   <= '0;
            bit_count_reg      <= '0;
            bit_shift_reg      <= '0;
            section_length_reg <= '0;
            char_index_reg     <= '0;
            key_equal_reg      <= 1'b1;
        end
        else if (step)
        begin
            phase_reg          <= phase_next;
            header_count_reg   <= header_count_next;
            bit_count_reg      <= bit_count_next;
            bit_shift_reg      <= bit_shift_next;
            section_length_reg <= section_length_next;
            char_index_reg     <= char_index_next;
            key_equal_reg      <= key_equal_next;
        end
    end

endmodule

`default_nettype wire

### rtl/lsb_stego_stream_extractor.sv
// Top level of the LSB stego stream extractor: config, input and result registers.
// A byte accepted into the input register gives its result (if any) in the result register when the parser steps it.
// Throughput: one image byte per cycle; the parser steps the byte in the input register
//   whenever the result register is empty or is being taken that cycle, else it waits.
// Reset: rst_n clears the parser to header skip, empties both registers and loads
//   the register defaults (header skip 54, empty passkey).
`default_nettype none

module lsb_stego_stream_extractor #(
    parameter int LENGTH_BITS = 32
) (
    input  wire                                clk,
    input  wire                                rst_n,
    // configuration write port
    input  wire                                cfg_we,
    input  wire [lse_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire [lse_pkg::CFG_DATA_W-1:0]      cfg_data,
    // image byte input channel
    input  wire                                in_valid,
    output logic                               in_stall,
    input  wire [7:0]                          image_byte,
    // hidden character output channel
    output logic                               out_valid,
    input  wire                                out_stall,
    output logic [lse_pkg::SEC_W-1:0]          section,
    output logic                               char_valid,
    output logic [7:0]                         char_value,
    output logic                               section_end,
    output logic                               key_match,
    output logic                               finished
);

    lse_pkg::lse_cfg_t    cfg_reg;
    lse_pkg::lse_result_t res, out_reg;
    logic                 res_valid;

    logic                 in_full_reg;
    logic                 in_bit_reg;
    logic                 out_full_reg;
    logic                 advance;
    logic                 in_take;
    logic                 step;

    // Configuration registers; the user must write them only while the stream is idle (not enforced here).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_skip         <= lse_pkg::HEADER_SKIP_RESET;
            cfg_reg.passkey_length      <= '0;
            cfg_reg.passkey_first_chars <= '0;
            cfg_reg.passkey_ninth_char  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lse_pkg::REG_HEADER_SKIP: cfg_reg.header_skip <= cfg_data[7:0];
                lse_pkg::REG_KEY_LENGTH:  cfg_reg.passkey_length <= cfg_data[3:0];
                lse_pkg::REG_KEY_FIRST:   cfg_reg.passkey_first_chars <= cfg_data;
                lse_pkg::REG_KEY_NINTH:   cfg_reg.passkey_ninth_char <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // The byte in the input register is consumed whenever the result register
    // can take whatever it produces: empty now, or being drained this cycle.
    assign advance  = !out_full_reg || !out_stall;
    assign step     = in_full_reg && advance;
    assign in_stall = in_full_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // Only the LSB of each image byte carries hidden data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_take || step)
        begin
            in_full_reg <= in_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_bit_reg <= image_byte[0];
        end
    end

    lse_parse #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_bit  (in_bit_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register: holds one word until the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_full_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_full_reg <= step && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && step && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_full_reg;
    assign section     = out_reg.section;
    assign char_valid  = out_reg.char_valid;
    assign char_value  = out_reg.char_value;
    assign section_end = out_reg.section_end;
    assign key_match   = out_reg.key_match;
    assign finished    = out_reg.finished;

    a_finished_on_data_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && finished |-> section_end && section == lse_pkg::SEC_DATA)
        else $error("finished outside the end of the data section");

    a_match_on_magic_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_match |-> section_end && section == lse_pkg::SEC_MAGIC)
        else $error("key_match outside the end of the magic section");

    a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !char_valid |-> section_end && char_value == 8'd0)
        else $error("result without a character is not an empty section marker");

    a_input_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_full_reg && out_full_reg)
        else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

### sim/lsb_stego_stream_extractor_tb.sv
// Self-checking testbench for the LSB stego stream extractor.

module lsb_stego_stream_extractor_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEN_BITS      = 32;
    localparam int DATA_CHARS    = 160;     // file data characters in the stream
    localparam int SETTLE_CYCLES = 4;       // drain margin after the last predicted word
    localparam int CYCLE_LIMIT   = 200000;

    // parser position as seen by the predictor
    typedef enum logic [2:0] {PS_SKIP, PS_LENGTH, PS_CHARS, PS_STOPPED, PS_DONE} parse_state_t;

    // Predicts the extracted characters from the accepted image bytes and
    // checks each result word against the oldest prediction.
    class ExtractScoreboard;
        lse_pkg::lse_cfg_t    regs;
        parse_state_t         st;
        logic [1:0]           sec;
        logic [7:0]           skipped;
        int unsigned          bit_cnt;
        logic [31:0]          shreg;
        logic [31:0]          sec_len;
        logic [31:0]          char_idx;
        logic                 key_ok;
        lse_pkg::lse_result_t expected[$];
        int                   errors;

        function new();
            regs.header_skip         = lse_pkg::HEADER_SKIP_RESET;
            regs.passkey_length      = '0;
            regs.passkey_first_chars = '0;
            regs.passkey_ninth_char  = '0;
            st       = PS_SKIP;
            sec      = lse_pkg::SEC_MAGIC;
            skipped  = '0;
            bit_cnt  = 0;
            shreg    = '0;
            sec_len  = '0;
            char_idx = '0;
            key_ok   = 1'b1;
            errors   = 0;
        endfunction

        function void write_reg(logic [lse_pkg::CFG_INDEX_W-1:0] idx,
                                logic [lse_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                lse_pkg::REG_HEADER_SKIP: regs.header_skip         = data[7:0];
                lse_pkg::REG_KEY_LENGTH:  regs.passkey_length      = data[3:0];
                lse_pkg::REG_KEY_FIRST:   regs.passkey_first_chars = data;
                lse_pkg::REG_KEY_NINTH:   regs.passkey_ninth_char  = data[7:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] key_char(logic [31:0] idx);
            int base;
            base = 63 - 8 * int'(idx);
            if (idx < 8)
                return regs.passkey_first_chars[base -: 8];
            return regs.passkey_ninth_char;
        endfunction

        // last word of a section: tag it, then move on, stop or finish
        function void close_section(logic valid, logic [7:0] ch);
            lse_pkg::lse_result_t r;
            r.section     = sec;
            r.char_valid  = valid;
            r.char_value  = ch;
            r.section_end = 1'b1;
            r.key_match   = (sec == lse_pkg::SEC_MAGIC) && key_ok;
            r.finished    = (sec == lse_pkg::SEC_DATA);
            expected.push_back(r);
            bit_cnt  = 0;
            shreg    = '0;
            char_idx = '0;
            case (sec)
                lse_pkg::SEC_MAGIC:
                begin
                    if (key_ok)
                    begin
                        sec = lse_pkg::SEC_EXT;
                        st  = PS_LENGTH;
                    end
                    else
                        st = PS_STOPPED;
                end
                lse_pkg::SEC_EXT:
                begin
                    sec = lse_pkg::SEC_DATA;
                    st  = PS_LENGTH;
                end
                default: st = PS_DONE;
            endcase
        endfunction

        function void note_byte(logic [7:0] b);
            lse_pkg::lse_result_t r;
            logic [7:0]           ch;
            logic                 last;
            if (st == PS_SKIP)
            begin
                if (skipped < regs.header_skip)
                begin
                    skipped = skipped + 8'd1;
                    return;
                end
                st      = PS_LENGTH;
                sec     = lse_pkg::SEC_MAGIC;
                bit_cnt = 0;
                shreg   = '0;
            end
            case (st)
                PS_LENGTH:
                begin
                    shreg = {shreg[30:0], b[0]} & (32'hFFFF_FFFF >> (32 - LEN_BITS));
                    if (bit_cnt + 1 < LEN_BITS)
                    begin
                        bit_cnt++;
                        return;
                    end
                    sec_len  = shreg;
                    bit_cnt  = 0;
                    shreg    = '0;
                    char_idx = '0;
                    if (sec == lse_pkg::SEC_MAGIC)
                        key_ok = (regs.passkey_length <= lse_pkg::KEY_MAX_CHARS) &&
                                 (sec_len == 32'(regs.passkey_length));
                    if (sec_len == 0)
                        close_section(1'b0, 8'h00);
                    else
                        st = PS_CHARS;
                end
                PS_CHARS:
                begin
                    shreg = {24'h0, shreg[6:0], b[0]};
                    if (bit_cnt < 7)
                    begin
                        bit_cnt++;
                        return;
                    end
                    ch      = shreg[7:0];
                    bit_cnt = 0;
                    shreg   = '0;
                    if (sec == lse_pkg::SEC_MAGIC &&
                        (char_idx >= lse_pkg::KEY_MAX_CHARS || key_char(char_idx) != ch))
                        key_ok = 1'b0;
                    last     = (char_idx + 32'd1 == sec_len);
                    char_idx = char_idx + 32'd1;
                    if (last)
                        close_section(1'b1, ch);
                    else
                    begin
                        r.section     = sec;
                        r.char_valid  = 1'b1;
                        r.char_value  = ch;
                        r.section_end = 1'b0;
                        r.key_match   = 1'b0;
                        r.finished    = 1'b0;
                        expected.push_back(r);
                    end
                end
                default: ;  // stopped or done: byte ignored
            endcase
        endfunction

        function string show(lse_pkg::lse_result_t r);
            return $sformatf("sec=%0d valid=%0b char=%02h end=%0b match=%0b fin=%0b",
                             r.section, r.char_valid, r.char_value, r.section_end,
                             r.key_match, r.finished);
        endfunction

        function void check_result(lse_pkg::lse_result_t got);
            lse_pkg::lse_result_t want;
            if (expected.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: %s", show(got));
                return;
            end
            want = expected.pop_front();
            if (got.section !== want.section || got.char_valid !== want.char_valid ||
                got.char_value !== want.char_value || got.section_end !== want.section_end ||
                got.key_match !== want.key_match || got.finished !== want.finished)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %s, got %s", show(want), show(got));
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [lse_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [lse_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                            in_valid;
    logic                            in_stall;
    logic [7:0]                      image_byte;
    logic                            out_valid;
    logic                            out_stall;
    logic [lse_pkg::SEC_W-1:0]       section;
    logic                            char_valid;
    logic [7:0]                      char_value;
    logic                            section_end;
    logic                            key_match;
    logic                            finished;

    ExtractScoreboard sb;
    int               cycles;
    logic             burst;        // both sides run without idling while set

    lsb_stego_stream_extractor #(.LENGTH_BITS(LEN_BITS)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .image_byte  (image_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .section     (section),
        .char_valid  (char_valid),
        .char_value  (char_value),
        .section_end (section_end),
        .key_match   (key_match),
        .finished    (finished)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: a hung handshake or lost word ends the run here.
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Both handshakes are sampled at the edge, before any update of that edge,
    // so a word counts exactly when valid was high and stall low going in.
    always @(posedge clk)
    begin
        lse_pkg::lse_result_t got;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_byte(image_byte);
            if (out_valid && !out_stall)
            begin
                got.section     = section;
                got.char_valid  = char_valid;
                got.char_value  = char_value;
                got.section_end = section_end;
                got.key_match   = key_match;
                got.finished    = finished;
                sb.check_result(got);
            end
        end
    end

    // Result side: stall for a random hold before each word, none in bursts.
    initial
    begin
        int hold;
        out_stall = 1'b1;
        @(posedge clk);
        forever
        begin
            hold = burst ? 0 : $urandom_range(0, 16);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // One image byte: optional gap with valid low, then hold until taken.
    // Valid stays high after acceptance so back-to-back words need no toggle.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if ($urandom_range(0, 99) == 0)
            burst = !burst;
        gap = burst ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        image_byte <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Hide a value in the LSBs, MSB first; the upper seven bits are noise.
    task automatic send_hidden(input logic [31:0] value, input int nbits);
        logic [7:0] b;
        for (int i = nbits - 1; i >= 0; i--)
        begin
            b    = 8'($urandom);
            b[0] = value[i];
            send_byte(b);
        end
    endtask

    // Drain: no input, all predicted words out, then a few cycles for any
    // byte that produces no word to clear the pipeline.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [lse_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [lse_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // random register value, extremes one time in three each
    function automatic logic [lse_pkg::CFG_DATA_W-1:0] pick_value();
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial
    begin
        logic [63:0] key_first;
        logic [7:0]  key_ninth;
        int          pre_skip;
        sb         = new();
        burst      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = lse_pkg::REG_HEADER_SKIP;
        cfg_data   = '0;
        in_valid   = 1'b0;
        image_byte = '0;
        rst_n      = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full-length passkey so the ninth character register is compared too.
        key_first = {$urandom, $urandom};
        key_ninth = 8'($urandom);
        write_reg(lse_pkg::REG_HEADER_SKIP, 64'd255);
        write_reg(lse_pkg::REG_KEY_LENGTH, 64'd9);
        write_reg(lse_pkg::REG_KEY_FIRST, key_first);
        write_reg(lse_pkg::REG_KEY_NINTH, {56'h0, key_ninth});

        // Part of a long header, then the skip is cut to zero mid-header:
        // hidden bits must start with the very next byte.
        pre_skip = $urandom_range(1, 20);
        repeat (pre_skip) send_byte(8'($urandom));
        settle();
        write_reg(lse_pkg::REG_HEADER_SKIP, 64'd0);

        // Magic section equal to the passkey, so parsing carries on.
        send_hidden(32'd9, LEN_BITS);
        for (int i = 0; i < 8; i++)
            send_hidden({24'h0, key_first[63 - 8 * i -: 8]}, 8);
        send_hidden({24'h0, key_ninth}, 8);
        settle();

        // Passkey is no longer used past the magic section; run the registers
        // through their extremes, including a length that can never match.
        write_reg(lse_pkg::REG_KEY_LENGTH, 64'd15);
        write_reg(lse_pkg::REG_KEY_FIRST, '1);
        write_reg(lse_pkg::REG_KEY_NINTH, 64'hFF);
        write_reg(lse_pkg::REG_KEY_LENGTH, 64'd0);

        // Empty extension: a single word with no character and section end.
        send_hidden(32'd0, LEN_BITS);

        // File data with random characters; pause now and then to rewrite a
        // register, which must not disturb the data section.
        send_hidden(32'(DATA_CHARS), LEN_BITS);
        for (int i = 0; i < DATA_CHARS; i++)
        begin
            send_hidden({24'h0, 8'($urandom)}, 8);
            if (i % 32 == 31 && i != DATA_CHARS - 1)
            begin
                settle();
                write_reg(lse_pkg::CFG_INDEX_W'($urandom_range(0, 3)), pick_value());
            end
        end

        // Once finished, every further byte is dropped without a word.
        repeat (30) send_byte(8'($urandom));

        settle();
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
